@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of this project.
// Each macro checks on the rising clock edge and is disabled while reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// The expression must hold in every cycle.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

`endif

@@ rtl/core/swdv_pkg.sv @@
package swdv_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 5;
    localparam int LEVEL_W = $clog2(DEPTH + 1);
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W   = (CAP_W > LEVEL_W) ? CAP_W : LEVEL_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_DELETE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Per-cell control: load the pushed word, or take the upper neighbor's word.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

@@ rtl/core/swdv_cell.sv @@
module swdv_cell
    import swdv_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_operand,
    input  logic [DATA_W-1:0] i_upper,
    output logic [DATA_W-1:0] o_value,
    output logic              o_match
);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.load) begin
            n_value = i_operand;
        end else if (i_ctl.shift) begin
            n_value = i_upper;
        end
    end

    // The word is undefined until a push writes it, so it has no reset.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_match = (r_value == i_operand);

endmodule

@@ rtl/core/stack_with_delete_by_value.sv @@
// Bounded LIFO stack of signed 32-bit words with push, pop, peek, delete by value and clear.
// Every accepted operation yields exactly one result, in the cycle after its transfer. A
// new operation may be transferred in every cycle as long as the downstream side takes each
// result. The result sits in a single output register, so while a held result is stalled
// the input side stalls as well. The entries live in a
// row of cells, one word per cell; every cell compares its word with the operand at once, the
// topmost valid match is picked by a masked OR over the match vector, and on a delete every
// cell at or above that match takes its upper neighbor's word in the same cycle. A push into
// a stack that holds no fewer entries than the effective capacity (the configured capacity,
// capped at the stack depth) reports overflow. Pop, peek or delete on an empty stack report
// empty; a delete that finds nothing reports not found and leaves the stack unchanged.
// Data is nonzero only for a successful pop or peek, and every result carries the level
// after the operation. Unknown op codes are accepted, do nothing and report ok. The capacity
// register resets to 16 and may be written only while no operation is in flight.
module stack_with_delete_by_value
    import swdv_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration
    input  logic                      i_cfg_we,
    input  logic [CAP_W-1:0]          i_cfg_wdata,
    // Operation channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [2:0]                i_op,
    input  logic signed [DATA_W-1:0]  i_operand_value,
    // Result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic signed [DATA_W-1:0]  o_data_out,
    output logic [LEVEL_W-1:0]        o_level
);

    `include "assert_macros.svh"

    logic [CAP_W-1:0]   r_capacity;
    logic [LEVEL_W-1:0] r_fill;
    logic [LEVEL_W-1:0] n_fill;

    logic               r_out_valid;
    t_status            r_status;
    logic [DATA_W-1:0]  r_data;
    logic [LEVEL_W-1:0] r_level;

    logic               in_xfer;
    t_op                op_e;
    logic [DATA_W-1:0]  operand;
    logic [CMP_W-1:0]   cap_eff;
    logic [CMP_W-1:0]   fill_x;
    logic               is_empty;
    logic               is_full;
    logic [IDX_W-1:0]   top_idx;
    logic [DATA_W-1:0]  top_val;
    logic               hit;
    logic               push_en;
    logic               del_en;
    t_status            st;
    logic [DATA_W-1:0]  data;

    logic [DATA_W-1:0]  cell_val   [DEPTH];
    logic [DEPTH-1:0]   cell_match;
    logic [DEPTH-1:0]   vmatch;
    logic [DEPTH-1:0]   load_vec;
    logic [DEPTH-1:0]   shift_vec;
    t_cell_ctl          cell_ctl   [DEPTH];

    // The input side stalls only when a finished result is held and not being taken.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign op_e    = t_op'(i_op);
    assign operand = i_operand_value;

    // Capacities above the depth behave like the depth itself.
    assign cap_eff  = (CMP_W'(r_capacity) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(r_capacity);
    assign fill_x   = CMP_W'(r_fill);
    assign is_empty = (r_fill == '0);
    assign is_full  = (fill_x >= cap_eff) || (fill_x >= CMP_W'(DEPTH));

    assign top_idx = IDX_W'(r_fill - LEVEL_W'(1));
    assign top_val = cell_val[top_idx];
    assign hit     = |vmatch;

    always_comb begin
        n_fill  = r_fill;
        st      = ST_OK;
        data    = '0;
        push_en = 1'b0;
        del_en  = 1'b0;
        case (op_e)
            OP_PUSH: begin
                if (is_full) begin
                    st = ST_OVERFLOW;
                end else begin
                    push_en = 1'b1;
                    n_fill  = r_fill + LEVEL_W'(1);
                end
            end
            OP_POP, OP_PEEK: begin
                if (is_empty) begin
                    st = ST_EMPTY;
                end else begin
                    data = top_val;
                    if (op_e == OP_POP) begin
                        n_fill = r_fill - LEVEL_W'(1);
                    end
                end
            end
            OP_DELETE: begin
                if (is_empty) begin
                    st = ST_EMPTY;
                end else if (!hit) begin
                    st = ST_NOT_FOUND;
                end else begin
                    del_en = 1'b1;
                    n_fill = r_fill - LEVEL_W'(1);
                end
            end
            OP_CLEAR: begin
                n_fill = '0;
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    // The row of cells. A cell shifts on a delete when no valid match lies above it, which
    // with a hit means it sits at or above the topmost match. Cells past the fill level hold
    // words that are never read, so they may shift freely.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DATA_W-1:0] upper;
        logic [DEPTH-1:0]  above;

        if (k == DEPTH - 1) begin : g_top
            assign upper = cell_val[k];
        end else begin : g_mid
            assign upper = cell_val[k+1];
        end

        assign above        = vmatch >> (k + 1);
        assign vmatch[k]    = cell_match[k] && (LEVEL_W'(k) < r_fill);
        assign load_vec[k]  = in_xfer && push_en && (r_fill == LEVEL_W'(k));
        assign shift_vec[k] = in_xfer && del_en && !(|above);
        assign cell_ctl[k]  = '{load: load_vec[k], shift: shift_vec[k]};

        swdv_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (cell_ctl[k]),
            .i_operand (operand),
            .i_upper   (upper),
            .o_value   (cell_val[k]),
            .o_match   (cell_match[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_status <= st;
            r_data   <= data;
            r_level  <= n_fill;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data_out  = r_data;
    assign o_level     = r_level;

    `ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, in_xfer && push_en,
        r_fill == $past(r_fill) + LEVEL_W'(1), "successful push did not raise the level by one")
    `ASSERT_NEXT(a_idle_keeps_fill, i_clk, i_rst_n, !in_xfer,
        r_fill == $past(r_fill), "level changed without a transfer")
    `ASSERT_ALWAYS(a_one_load, i_clk, i_rst_n, $onehot0(load_vec),
        "more than one cell loaded by a push")
    `ASSERT_IMPLY(a_err_zero_data, i_clk, i_rst_n, r_out_valid && r_status != ST_OK,
        r_data == '0, "error result carries nonzero data")
    `ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, fill_x <= CMP_W'(DEPTH),
        "level exceeds the stack depth")

endmodule

@@ sim/stack_result_checker.sv @@
module stack_result_checker
    import swdv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CAP_W-1:0]    i_cfg_wdata,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [2:0]          i_op,
    input  logic [DATA_W-1:0]   i_operand_value,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [1:0]          i_status,
    input  logic [DATA_W-1:0]   i_data_out,
    input  logic [LEVEL_W-1:0]  i_level,
    output int                  o_error_count,
    output int                  o_pending
);

    typedef struct packed {
        t_status             status;
        logic [DATA_W-1:0]   data;
        logic [LEVEL_W-1:0]  level;
    } t_stack_result;

    // Shadow copy of the stack and of the capacity register.
    logic [DATA_W-1:0] stack_words [DEPTH];
    int unsigned       stack_fill;
    logic [CAP_W-1:0]  cap_setting;
    t_stack_result     awaited_results [$];

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t: stack check failed on %s: got %h, expected %h", $time, what, got, want);
        o_error_count++;
    endtask

    // Applies one operation to the shadow stack and returns the result it must produce.
    task automatic apply_stack_op(input logic [2:0] code, input logic [DATA_W-1:0] value,
                                  output t_stack_result res);
        int unsigned room;
        int          hit;
        room = (cap_setting > DEPTH) ? DEPTH : cap_setting;
        hit = -1;
        res.status = ST_OK;
        res.data = '0;
        case (code)
            OP_PUSH: begin
                if (stack_fill >= room) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    stack_words[stack_fill] = value;
                    stack_fill++;
                end
            end
            OP_POP, OP_PEEK: begin
                if (stack_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data = stack_words[stack_fill - 1];
                    if (code == OP_POP) stack_fill--;
                end
            end
            OP_DELETE: begin
                for (int i = int'(stack_fill) - 1; i >= 0; i--) begin
                    if (hit < 0 && stack_words[i] == value) hit = i;
                end
                if (stack_fill == 0) begin
                    res.status = ST_EMPTY;
                end else if (hit < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    // Entries above the match slide down one place.
                    for (int k = hit; k + 1 < int'(stack_fill); k++) begin
                        stack_words[k] = stack_words[k + 1];
                    end
                    stack_fill--;
                end
            end
            OP_CLEAR: stack_fill = 0;
            default: ;
        endcase
        res.level = LEVEL_W'(stack_fill);
    endtask

    always @(posedge i_clk) begin : watch
        t_stack_result expected;
        if (!i_rst_n) begin
            awaited_results.delete();
            stack_fill = 0;
            cap_setting = CAP_RESET;
        end else begin
            if (i_cfg_we) cap_setting = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                apply_stack_op(i_op, i_operand_value, expected);
                awaited_results.push_back(expected);
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with nothing pending (data)", i_data_out, '0);
                end else begin
                    expected = awaited_results.pop_front();
                    if (i_status !== expected.status)
                        report_mismatch("status", DATA_W'(i_status), DATA_W'(expected.status));
                    if (i_data_out !== expected.data)
                        report_mismatch("data_out", i_data_out, expected.data);
                    if (i_level !== expected.level)
                        report_mismatch("level", DATA_W'(i_level), DATA_W'(expected.level));
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

@@ sim/tb_stack_with_delete_by_value.sv @@
module tb_stack_with_delete_by_value;
    import swdv_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 6;
    // The block answers in the cycle after a transfer; the settle wait covers it with margin.
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_CYCLES     = 80;
    localparam int IDLE_PCT        = 21;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int CYCLE_LIMIT     = 100000;

    // Op codes beyond clear are accepted by the block and do nothing.
    localparam logic [2:0] OP_NOP_A = 3'd5;
    localparam logic [2:0] OP_NOP_B = 3'd6;
    localparam logic [2:0] OP_NOP_C = 3'd7;

    localparam logic [DATA_W-1:0] ZERO_WORD = '0;
    localparam logic [DATA_W-1:0] ONE_WORD  = 32'h0000_0001;
    localparam logic [DATA_W-1:0] MAX_WORD  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MIN_WORD  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] ODD_WORD  = 32'h5A5A_5A5A;

    // Every input of the block starts at a known value.
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CAP_W-1:0]    cfg_wdata = '0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [2:0]          op_code   = OP_PUSH;
    logic [DATA_W-1:0]   operand   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          status;
    logic [DATA_W-1:0]   data_out;
    logic [LEVEL_W-1:0]  level;

    int error_count;
    int pending;
    int cycle_count = 0;

    // Receiver control: idling on or off, and requests for a long hold-off.
    logic idle_en       = 1'b1;
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   hold_left     = 0;

    // Small set of values that pushes and deletes share, so that deletes find matches.
    logic [DATA_W-1:0] value_pool [8];

    stack_with_delete_by_value i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_op            (op_code),
        .i_operand_value (operand),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (status),
        .o_data_out      (data_out),
        .o_level         (level)
    );

    stack_result_checker stack_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_op            (op_code),
        .i_operand_value (operand),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_status        (status),
        .i_data_out      (data_out),
        .i_level         (level),
        .o_error_count   (error_count),
        .o_pending       (pending)
    );

    always #HALF_PERIOD clk = ~clk;

    // The receiver decides its stall once per cycle at the falling edge. A hold-off request
    // from the stimulus side makes it stall for the length that HOLD_CYCLES sets, counted
    // down here, so the output register stays full and the block has to stall its input.
    always @(negedge clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (idle_en) begin
            out_stall <= ($urandom_range(99) < IDLE_PCT);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Offers one operation and returns at the falling edge after its transfer. The optional
    // gap before it drops valid for whole cycles; when there is no gap, valid simply stays
    // high and the payload changes to the next operation.
    task automatic send_op(input logic [2:0] code, input logic [DATA_W-1:0] value);
        if (idle_en) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        op_code <= code;
        operand <= value;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // The capacity register may only change while nothing is in flight, so every result
    // already owed must have arrived, plus a short margin, before the write.
    task automatic drain_and_configure(input logic [CAP_W-1:0] cap);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // One phase of random traffic at a given capacity. Pushes outweigh pops so the stack
    // climbs toward its limit, and most values come from a small shared set so that deletes
    // often hit, sometimes on duplicates, and slide entries down from the middle.
    task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int push_pct,
                                    input logic quiet, input logic hold_off);
        int                pick;
        logic [2:0]        code;
        logic [DATA_W-1:0] value;
        drain_and_configure(cap);
        idle_en <= !quiet;
        if (hold_off) hold_requests <= hold_requests + 1;
        foreach (value_pool[i]) begin
            case ($urandom_range(3))
                0: value_pool[i] = $urandom;
                1: value_pool[i] = ($urandom_range(1) == 0) ? MAX_WORD : MIN_WORD;
                default: value_pool[i] = DATA_W'($urandom_range(7));
            endcase
        end
        repeat (ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < push_pct) code = OP_PUSH;
            else if (pick < push_pct + 15) code = OP_POP;
            else if (pick < push_pct + 25) code = OP_PEEK;
            else if (pick < 95) code = OP_DELETE;
            else if (pick < 98) code = OP_CLEAR;
            else code = 3'($urandom_range(OP_NOP_C, OP_NOP_A));
            value = ($urandom_range(4) == 0) ? $urandom : value_pool[$urandom_range(7)];
            send_op(code, value);
        end
    endtask

    // The run ends here with a failure if the stimulus or the drain ever hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at a capacity of three: pop, peek, delete and push on an empty stack, the
        // extreme words, overflow, a miss, a delete from the middle, the unused op codes,
        // clear, and a delete that must take the topmost of two equal entries.
        drain_and_configure(CAP_W'(3));
        send_op(OP_POP, ZERO_WORD);
        send_op(OP_PEEK, ALL_ONES);
        send_op(OP_DELETE, ZERO_WORD);
        send_op(OP_PUSH, MAX_WORD);
        send_op(OP_PUSH, MIN_WORD);
        send_op(OP_PUSH, ALL_ONES);
        send_op(OP_PUSH, ZERO_WORD);
        send_op(OP_PEEK, ZERO_WORD);
        send_op(OP_DELETE, ODD_WORD);
        send_op(OP_DELETE, MIN_WORD);
        send_op(OP_NOP_A, MAX_WORD);
        send_op(OP_NOP_B, MIN_WORD);
        send_op(OP_NOP_C, ALL_ONES);
        send_op(OP_POP, ZERO_WORD);
        send_op(OP_CLEAR, ALL_ONES);
        send_op(OP_PUSH, ZERO_WORD);
        send_op(OP_PUSH, ZERO_WORD);
        send_op(OP_PUSH, ONE_WORD);
        send_op(OP_DELETE, ZERO_WORD);

        // Capacity zero while two entries are held: pushes overflow, the rest still works.
        drain_and_configure('0);
        send_op(OP_PUSH, ODD_WORD);
        send_op(OP_PEEK, ZERO_WORD);
        send_op(OP_DELETE, ONE_WORD);
        send_op(OP_POP, ZERO_WORD);
        send_op(OP_POP, ZERO_WORD);

        // Random phases over a spread of capacities, the extremes among them. The first one
        // starts with a long receiver hold-off, and the second runs with no idling at all.
        run_random_phase(CAP_W'(31), 45, 1'b0, 1'b1);
        run_random_phase(CAP_W'(16), 40, 1'b1, 1'b0);
        run_random_phase(CAP_W'(1),  35, 1'b0, 1'b0);
        run_random_phase(CAP_W'(0),  30, 1'b0, 1'b0);
        run_random_phase(CAP_W'(2),  40, 1'b0, 1'b0);
        run_random_phase(CAP_W'(15), 45, 1'b0, 1'b0);
        run_random_phase(CAP_W'(17), 30, 1'b0, 1'b0);
        run_random_phase(CAP_W'(8),  40, 1'b0, 1'b0);
        run_random_phase(CAP_W'($urandom_range(31)), 40, 1'b0, 1'b0);

        // Let every owed result arrive, then allow the block's latency to pass.
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
